// ----- rtl/kpg_pkg.sv -----
package kpg_pkg;

   localparam int CFG_W  = 5;
   localparam int ELEM_W = 4;
   localparam int POS_W  = 4;
   localparam int REQ_W  = 8;
   localparam int RSP_W  = 8;

   localparam logic [0:0] REG_POOL_SIZE   = 1'b0;
   localparam logic [0:0] REG_PERM_LENGTH = 1'b1;

   localparam logic [CFG_W-1:0] POOL_SIZE_RST   = 5'd4;
   localparam logic [CFG_W-1:0] PERM_LENGTH_RST = 5'd4;

   typedef struct packed {
      logic clear;
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ----- rtl/kpg_ram.sv -----
module kpg_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/kpg_store.sv -----
module kpg_store #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kpg_pkg::mem_ctl_type     ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [WIDTH-1:0]         rd_init,
   output logic [WIDTH-1:0]         rd_data
);

   logic [DEPTH-1:0] valid_ff;
   logic             rd_valid_ff;
   logic             fwd_hit_ff;
   logic [WIDTH-1:0] fwd_data_ff;
   logic [WIDTH-1:0] init_ff;
   logic [WIDTH-1:0] ram_q;
   logic             fwd_hit;

   kpg_ram #(
      .WIDTH(WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctl.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctl.rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   assign fwd_hit = ctl.wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (ctl.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         fwd_hit_ff  <= fwd_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         fwd_data_ff <= wr_data;
         init_ff     <= rd_init;
      end
   end

   assign rd_data = fwd_hit_ff  ? fwd_data_ff :
                    rd_valid_ff ? ram_q       : init_ff;

endmodule

// ----- rtl/k_permutation_generator.sv -----
// Flow: after a (re)start the first permutation is read out of the index array and sent as
// it stands; when the run is already over, the exhausted result is sent instead.
// Next permutation: each counter level is read and checked, a carry rotates the tail at level i
// (at level n - 1 no write), then the swap, then each index is read out once the output is free.
// One request in work at a time. Synchronous reset: pool_size and perm_length to 4,
// enumeration restarted; array contents take their start values through valid bits.
module k_permutation_generator #(
   parameter int MAX_POOL = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [kpg_pkg::REQ_W-1:0]  req_tdata,   // [0] restart, [7:1] zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [kpg_pkg::RSP_W-1:0]  rsp_tdata,   // [3:0] element_index, [7:4] position
   output logic                       rsp_tlast,
   output logic                       rsp_tuser,   // [0] exhausted
   input  logic                       csr_wen,
   input  logic [0:0]                 csr_addr,
   input  logic [kpg_pkg::CFG_W-1:0]  csr_wdata
);

   localparam int IW = $clog2(MAX_POOL);
   localparam int NW = $clog2(MAX_POOL + 1);
   localparam int CW = (NW > kpg_pkg::CFG_W) ? NW : kpg_pkg::CFG_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CRD    = 4'd1;
   localparam logic [3:0] S_CCHK   = 4'd2;
   localparam logic [3:0] S_RSTART = 4'd3;
   localparam logic [3:0] S_RFIRST = 4'd4;
   localparam logic [3:0] S_RMOVE  = 4'd5;
   localparam logic [3:0] S_RLAST  = 4'd6;
   localparam logic [3:0] S_SRDA   = 4'd7;
   localparam logic [3:0] S_SRDB   = 4'd8;
   localparam logic [3:0] S_SWRA   = 4'd9;
   localparam logic [3:0] S_SWRB   = 4'd10;
   localparam logic [3:0] S_EMIT   = 4'd11;
   localparam logic [3:0] S_EXH    = 4'd12;

   logic [kpg_pkg::CFG_W-1:0] pool_size_ff,   pool_size_in;
   logic [kpg_pkg::CFG_W-1:0] perm_length_ff, perm_length_in;
   logic [3:0]                state_ff,       state_in;
   logic [IW-1:0]             i_ff,           i_in;
   logic [IW-1:0]             j_ff,           j_in;
   logic [NW-1:0]             ptr_ff,         ptr_in;
   logic [IW-1:0]             tmp_ff,         tmp_in;
   logic [IW-1:0]             em_ptr_ff,      em_ptr_in;
   logic [IW-1:0]             em_pos_ff,      em_pos_in;
   logic                      inflight_ff,    inflight_in;
   logic                      first_ff,       first_in;
   logic                      fin_run_ff,     fin_run_in;
   logic                      rsp_tvalid_ff,  rsp_tvalid_in;
   logic [kpg_pkg::RSP_W-1:0] rsp_tdata_ff,   rsp_tdata_in;
   logic                      rsp_tlast_ff,   rsp_tlast_in;
   logic                      rsp_tuser_ff,   rsp_tuser_in;

   logic [CW-1:0]  pool_ext;
   logic [CW-1:0]  n_full;
   logic [NW-1:0]  n;
   logic           bad_cfg;
   logic           out_free;
   logic           em_last;
   logic           restart;
   logic           eff_fin;
   logic           eff_first;
   logic [NW-1:0]  cnt_dec;

   kpg_pkg::mem_ctl_type idx_ctl;
   logic [IW-1:0]        idx_wr_addr;
   logic [IW-1:0]        idx_wr_data;
   logic [IW-1:0]        idx_rd_addr;
   logic [IW-1:0]        idx_q;

   kpg_pkg::mem_ctl_type cnt_ctl;
   logic [IW-1:0]        cnt_wr_addr;
   logic [NW-1:0]        cnt_wr_data;
   logic [IW-1:0]        cnt_rd_addr;
   logic [NW-1:0]        cnt_init;
   logic [NW-1:0]        cnt_q;

   assign pool_ext = CW'(pool_size_ff);
   assign n_full   = (pool_ext > CW'(MAX_POOL)) ? CW'(MAX_POOL) : pool_ext;
   assign n        = NW'(n_full);
   assign bad_cfg  = (perm_length_ff == '0) || (CW'(perm_length_ff) > n_full);
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign em_last  = ((CW'(em_pos_ff) + CW'(1)) == CW'(perm_length_ff));
   assign restart  = req_tdata[0];
   assign eff_fin  = bad_cfg || (!restart && fin_run_ff);
   assign eff_first = restart || first_ff;
   assign cnt_dec  = cnt_q - NW'(1);
   assign cnt_init = (CW'(cnt_rd_addr) < CW'(perm_length_ff)) ?
                     NW'(n - NW'(cnt_rd_addr)) : '0;

   assign req_tready = (state_ff == S_IDLE);

   kpg_store #(
      .WIDTH(IW),
      .DEPTH(MAX_POOL)
   ) u_idx (
      .clock  (clock),
      .reset  (reset),
      .ctl    (idx_ctl),
      .wr_addr(idx_wr_addr),
      .wr_data(idx_wr_data),
      .rd_addr(idx_rd_addr),
      .rd_init(idx_rd_addr),
      .rd_data(idx_q)
   );

   kpg_store #(
      .WIDTH(NW),
      .DEPTH(MAX_POOL)
   ) u_cnt (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cnt_ctl),
      .wr_addr(cnt_wr_addr),
      .wr_data(cnt_wr_data),
      .rd_addr(cnt_rd_addr),
      .rd_init(cnt_init),
      .rd_data(cnt_q)
   );

   always_comb begin
      pool_size_in   = pool_size_ff;
      perm_length_in = perm_length_ff;
      state_in       = state_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      ptr_in         = ptr_ff;
      tmp_in         = tmp_ff;
      em_ptr_in      = em_ptr_ff;
      em_pos_in      = em_pos_ff;
      inflight_in    = inflight_ff;
      first_in       = first_ff;
      fin_run_in     = fin_run_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tlast_in   = rsp_tlast_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      idx_ctl        = '0;
      idx_wr_addr    = '0;
      idx_wr_data    = '0;
      idx_rd_addr    = '0;
      cnt_ctl        = '0;
      cnt_wr_addr    = '0;
      cnt_wr_data    = '0;
      cnt_rd_addr    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (restart) begin
                  idx_ctl.clear = 1'b1;
                  cnt_ctl.clear = 1'b1;
                  fin_run_in    = 1'b0;
                  first_in      = 1'b1;
               end
               i_in        = IW'(perm_length_ff - kpg_pkg::CFG_W'(1));
               em_ptr_in   = '0;
               inflight_in = 1'b0;
               if (eff_fin) begin
                  state_in = S_EXH;
               end else if (eff_first) begin
                  first_in = 1'b0;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_CRD;
               end
            end
         end
         S_CRD: begin
            cnt_ctl.rd_en = 1'b1;
            cnt_rd_addr   = i_ff;
            state_in      = S_CCHK;
         end
         S_CCHK: begin
            if (cnt_q == '0) begin
               fin_run_in = 1'b1;
               state_in   = S_EXH;
            end else if (cnt_dec != '0) begin
               cnt_ctl.wr_en = 1'b1;
               cnt_wr_addr   = i_ff;
               cnt_wr_data   = cnt_dec;
               j_in          = IW'(n - cnt_dec);
               state_in      = S_SRDA;
            end else begin
               cnt_ctl.wr_en = 1'b1;
               cnt_wr_addr   = i_ff;
               cnt_wr_data   = NW'(n - NW'(i_ff));
               if (i_ff == '0) begin
                  fin_run_in = 1'b1;
                  state_in   = S_EXH;
               end else begin
                  state_in = S_RSTART;
               end
            end
         end
         S_RSTART: begin
            idx_ctl.rd_en = 1'b1;
            idx_rd_addr   = i_ff;
            ptr_in        = NW'(i_ff) + NW'(1);
            state_in      = S_RFIRST;
         end
         S_RFIRST: begin
            tmp_in = idx_q;
            if (ptr_ff < n) begin
               idx_ctl.rd_en = 1'b1;
               idx_rd_addr   = IW'(ptr_ff);
               ptr_in        = ptr_ff + NW'(1);
               state_in      = S_RMOVE;
            end else begin
               i_in     = i_ff - IW'(1);
               state_in = S_CRD;
            end
         end
         S_RMOVE: begin
            idx_ctl.wr_en = 1'b1;
            idx_wr_addr   = IW'(ptr_ff - NW'(2));
            idx_wr_data   = idx_q;
            if (ptr_ff < n) begin
               idx_ctl.rd_en = 1'b1;
               idx_rd_addr   = IW'(ptr_ff);
               ptr_in        = ptr_ff + NW'(1);
            end else begin
               state_in = S_RLAST;
            end
         end
         S_RLAST: begin
            idx_ctl.wr_en = 1'b1;
            idx_wr_addr   = IW'(n - NW'(1));
            idx_wr_data   = tmp_ff;
            i_in          = i_ff - IW'(1);
            state_in      = S_CRD;
         end
         S_SRDA: begin
            idx_ctl.rd_en = 1'b1;
            idx_rd_addr   = i_ff;
            state_in      = S_SRDB;
         end
         S_SRDB: begin
            tmp_in        = idx_q;
            idx_ctl.rd_en = 1'b1;
            idx_rd_addr   = j_ff;
            state_in      = S_SWRA;
         end
         S_SWRA: begin
            idx_ctl.wr_en = 1'b1;
            idx_wr_addr   = i_ff;
            idx_wr_data   = idx_q;
            state_in      = S_SWRB;
         end
         S_SWRB: begin
            idx_ctl.wr_en = 1'b1;
            idx_wr_addr   = j_ff;
            idx_wr_data   = tmp_ff;
            em_ptr_in     = '0;
            inflight_in   = 1'b0;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (inflight_ff) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {kpg_pkg::POS_W'(em_pos_ff), kpg_pkg::ELEM_W'(idx_q)};
               rsp_tlast_in  = em_last;
               rsp_tuser_in  = 1'b0;
               inflight_in   = 1'b0;
               if (em_last) begin
                  state_in = S_IDLE;
               end
            end else if (out_free) begin
               idx_ctl.rd_en = 1'b1;
               idx_rd_addr   = em_ptr_ff;
               em_pos_in     = em_ptr_ff;
               em_ptr_in     = em_ptr_ff + IW'(1);
               inflight_in   = 1'b1;
            end
         end
         S_EXH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tlast_in  = 1'b1;
               rsp_tuser_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wen) begin
         case (csr_addr)
            kpg_pkg::REG_POOL_SIZE:   pool_size_in   = csr_wdata;
            kpg_pkg::REG_PERM_LENGTH: perm_length_in = csr_wdata;
            default: begin
            end
         endcase
         idx_ctl.clear = 1'b1;
         cnt_ctl.clear = 1'b1;
         first_in      = 1'b1;
         fin_run_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff   <= kpg_pkg::POOL_SIZE_RST;
         perm_length_ff <= kpg_pkg::PERM_LENGTH_RST;
         state_ff       <= S_IDLE;
         inflight_ff    <= 1'b0;
         first_ff       <= 1'b1;
         fin_run_ff     <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         pool_size_ff   <= pool_size_in;
         perm_length_ff <= perm_length_in;
         state_ff       <= state_in;
         inflight_ff    <= inflight_in;
         first_ff       <= first_in;
         fin_run_ff     <= fin_run_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      ptr_ff       <= ptr_in;
      tmp_ff       <= tmp_in;
      em_ptr_ff    <= em_ptr_in;
      em_pos_ff    <= em_pos_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ----- tb/kpg_checker.sv -----
`timescale 1ns / 1ps

module kpg_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [kpg_pkg::REQ_W-1:0] req_tdata,   // [0] restart, [7:1] zero
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [kpg_pkg::RSP_W-1:0] rsp_tdata,   // [3:0] element_index, [7:4] position
   input  logic                      rsp_tlast,
   input  logic                      rsp_tuser,   // [0] exhausted
   input  logic                      csr_wen,
   input  logic [0:0]                csr_addr,
   input  logic [kpg_pkg::CFG_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   localparam int POOL_MAX = 16;

   typedef struct packed {
      logic [kpg_pkg::ELEM_W-1:0] element_index;
      logic [kpg_pkg::POS_W-1:0]  position;
      logic                       last;
      logic                       exhausted;
   } perm_beat_type;

   logic [kpg_pkg::CFG_W-1:0]  pool_size;
   logic [kpg_pkg::CFG_W-1:0]  perm_length;
   logic [kpg_pkg::ELEM_W-1:0] index_arr [POOL_MAX];
   logic [kpg_pkg::CFG_W-1:0]  cycle_cnt [POOL_MAX];
   logic [kpg_pkg::POS_W-1:0]  inner_pos;
   logic                       first_pending;
   logic                       finished;
   perm_beat_type              perm_beats_q [$];
   int                         mismatches = 0;

   assign fail_count = mismatches;

   function automatic int pool_n();
      return (pool_size > POOL_MAX) ? POOL_MAX : int'(pool_size);
   endfunction

   function automatic void restart_enum();
      int n;
      int r;
      int k;
      n = pool_n();
      r = perm_length;
      for (k = 0; k < POOL_MAX; k++) begin
         index_arr[k] = k[kpg_pkg::ELEM_W-1:0];
         cycle_cnt[k] = '0;
      end
      finished = (r == 0) || (r > n);
      if (!finished) begin
         for (k = 0; k < r; k++)
            cycle_cnt[k] = kpg_pkg::CFG_W'(n - k);
      end
      inner_pos = (r != 0) ? kpg_pkg::POS_W'(r - 1) : '0;
      first_pending = 1'b1;
   endfunction

   function automatic void push_exhausted();
      perm_beat_type b;
      b.element_index = '0;
      b.position = '0;
      b.last = 1'b1;
      b.exhausted = 1'b1;
      perm_beats_q = {perm_beats_q, b};
   endfunction

   function automatic void push_perm();
      perm_beat_type b;
      int r;
      int k;
      r = perm_length;
      for (k = 0; k < r && k < POOL_MAX; k++) begin
         b.element_index = index_arr[k];
         b.position = k[kpg_pkg::POS_W-1:0];
         b.last = (k + 1 == r);
         b.exhausted = 1'b0;
         perm_beats_q = {perm_beats_q, b};
      end
   endfunction

   function automatic void predict_next_perm(input logic restart);
      int n;
      int i;
      int j;
      int k;
      logic [kpg_pkg::ELEM_W-1:0] t;
      n = pool_n();
      if (restart)
         restart_enum();
      if (finished) begin
         push_exhausted();
         return;
      end
      if (first_pending) begin
         first_pending = 1'b0;
         push_perm();
         return;
      end
      i = inner_pos;
      if (i >= POOL_MAX || cycle_cnt[i] == 0) begin
         finished = 1'b1;
         push_exhausted();
         return;
      end
      cycle_cnt[i] = cycle_cnt[i] - 1'b1;
      while (cycle_cnt[i] == 0) begin
         // rotate the tail left by one, carry into the level above
         t = index_arr[i];
         for (k = i; k + 1 < n; k++)
            index_arr[k] = index_arr[k + 1];
         if (n > 0 && i < n)
            index_arr[n - 1] = t;
         cycle_cnt[i] = kpg_pkg::CFG_W'(n - i);
         if (i == 0) begin
            finished = 1'b1;
            push_exhausted();
            return;
         end
         i--;
         cycle_cnt[i] = cycle_cnt[i] - 1'b1;
      end
      j = n - int'(cycle_cnt[i]);
      if (j >= 0 && j < POOL_MAX) begin
         t = index_arr[j];
         index_arr[j] = index_arr[i];
         index_arr[i] = t;
      end
      inner_pos = kpg_pkg::POS_W'(perm_length - 1'b1);
      push_perm();
   endfunction

   always @(posedge clock) begin
      perm_beat_type want;
      logic ok;
      if (reset) begin
         pool_size = kpg_pkg::POOL_SIZE_RST;
         perm_length = kpg_pkg::PERM_LENGTH_RST;
         restart_enum();
         perm_beats_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (perm_beats_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t unexpected transfer: idx %0d pos %0d last %0b exh %0b",
                           $realtime, rsp_tdata[kpg_pkg::ELEM_W-1:0],
                           rsp_tdata[kpg_pkg::ELEM_W +: kpg_pkg::POS_W],
                           rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = perm_beats_q.pop_front();
               ok = (rsp_tdata[kpg_pkg::ELEM_W-1:0] === want.element_index) &&
                    (rsp_tdata[kpg_pkg::ELEM_W +: kpg_pkg::POS_W] === want.position) &&
                    (rsp_tlast === want.last) &&
                    (rsp_tuser === want.exhausted);
               if (!ok) begin
                  if (mismatches < 10)
                     $display("%0t mismatch: expected idx %0d pos %0d last %0b exh %0b, %s",
                              $realtime, want.element_index, want.position, want.last,
                              want.exhausted,
                              $sformatf("got idx %0d pos %0d last %0b exh %0b",
                                        rsp_tdata[kpg_pkg::ELEM_W-1:0],
                                        rsp_tdata[kpg_pkg::ELEM_W +: kpg_pkg::POS_W],
                                        rsp_tlast, rsp_tuser));
                  mismatches++;
               end
            end
         end
         if (csr_wen) begin
            if (csr_addr == kpg_pkg::REG_POOL_SIZE)
               pool_size = csr_wdata;
            else
               perm_length = csr_wdata;
            restart_enum();
         end
         if (req_tvalid && req_tready)
            predict_next_perm(req_tdata[0]);
      end
      pending <= perm_beats_q.size();
   end

endmodule

// ----- tb/k_permutation_generator_tb.sv -----
`timescale 1ns / 1ps

module k_permutation_generator_tb;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [kpg_pkg::REQ_W-1:0] req_tdata = '0;   // [0] restart, [7:1] zero
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [kpg_pkg::RSP_W-1:0] rsp_tdata;        // [3:0] element_index, [7:4] position
   logic                      rsp_tlast;
   logic                      rsp_tuser;        // [0] exhausted
   logic                      csr_wen = 1'b0;
   logic [0:0]                csr_addr = kpg_pkg::REG_POOL_SIZE;
   logic [kpg_pkg::CFG_W-1:0] csr_wdata = '0;
   int                        fail_count;
   int                        pending;
   bit                        calm = 1'b0;
   int                        hold_left = 0;
   int                        sent = 0;

   k_permutation_generator #(
      .MAX_POOL(16)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   kpg_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // stall the result side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         hold_left <= gap_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_req(input logic restart);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 2) == 0)
         gap = gap_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(kpg_pkg::REQ_W-1){1'b0}}, restart};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // hold off until every expected transfer has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] addr,
                            input logic [kpg_pkg::CFG_W-1:0] value);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [kpg_pkg::CFG_W-1:0] pool,
                             input logic [kpg_pkg::CFG_W-1:0] len);
      write_reg(kpg_pkg::REG_POOL_SIZE, pool);
      write_reg(kpg_pkg::REG_PERM_LENGTH, len);
   endtask

   initial begin
      int pool;
      int len;
      int count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      repeat (3) send_req(1'b0);
      drain();
      set_config(5'd3, 5'd2);
      repeat (7) send_req(1'b0);
      send_req(1'b1);
      drain();
      set_config(5'd1, 5'd1);
      repeat (2) send_req(1'b0);
      drain();
      set_config(5'd2, 5'd3);
      send_req(1'b0);
      drain();
      calm = 1'b1;
      set_config(5'd20, 5'd16);
      repeat (2) send_req(1'b0);
      drain();
      calm = 1'b0;
      set_config(5'd16, 5'd1);
      repeat (3) send_req(1'b0);
      send_req(1'b1);
      drain();

      while (sent < 180) begin
         count = $urandom_range(0, 9);
         if (count < 6)
            pool = $urandom_range(1, 5);
         else if (count < 9)
            pool = $urandom_range(6, 16);
         else
            pool = $urandom_range(17, 31);
         if ($urandom_range(0, 4) == 0)
            len = $urandom_range(1, 16);
         else
            len = $urandom_range(1, (pool > 16) ? 16 : pool);
         case ($urandom_range(0, 3))
            0: write_reg(kpg_pkg::REG_POOL_SIZE, kpg_pkg::CFG_W'(pool));
            1: write_reg(kpg_pkg::REG_PERM_LENGTH, kpg_pkg::CFG_W'(len));
            default: set_config(kpg_pkg::CFG_W'(pool), kpg_pkg::CFG_W'(len));
         endcase
         calm = ($urandom_range(0, 3) == 0);
         count = $urandom_range(4, 24);
         repeat (count) send_req($urandom_range(0, 9) == 0);
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[k_permutation_generator] OK");
      else
         $display("[k_permutation_generator] ERROR");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("[k_permutation_generator] ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/kpg_pkg.sv
rtl/kpg_ram.sv
rtl/kpg_store.sv
rtl/k_permutation_generator.sv
tb/kpg_checker.sv
tb/k_permutation_generator_tb.sv
